FILE: hdl/ghst_pkg.sv
// Package: shared constants, codes and transaction types for the handle slot table.
`default_nettype none
package ghst_pkg;

    localparam int SLOTS   = 8;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int HND_W   = 32;
    localparam int GEN_W   = HND_W - IDX_W;
    localparam int CNT_W   = 4;
    localparam int KIND_W  = 2;
    localparam int LIMIT_W = 4;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(SLOTS);
    localparam logic [GEN_W-1:0]   GEN_MAX     = {GEN_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_RESERVE   = 2'd0,
        MODE_LOOKUP    = 2'd1,
        MODE_CLOSE     = 2'd2,
        MODE_CLOSE_ALL = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SLOT    = 2'd1,
        ST_BAD_HANDLE = 2'd2
    } status_t;

    typedef struct packed {
        mode_t              mode;
        logic [KIND_W-1:0]  kind;
        logic [HND_W-1:0]   handle;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [HND_W-1:0]   handle;
        logic [IDX_W-1:0]   slot_index;
        logic [CNT_W-1:0]   open_count;
    } rsp_t;

endpackage
`default_nettype wire

FILE: hdl/ghst_if.sv
// Interfaces: request and response channels with valid/ready handshake.
`default_nettype none
interface ghst_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [1:0]  kind;
    logic [31:0] handle_in;

    modport source (output valid, output mode, output kind, output handle_in, input ready);
    modport sink   (input valid, input mode, input kind, input handle_in, output ready);
endinterface

interface ghst_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] handle_out;
    logic [2:0]  slot_index;
    logic [3:0]  open_count;

    modport source (output valid, output status, output handle_out, output slot_index,
                    output open_count, input ready);
    modport sink   (input valid, input status, input handle_out, input slot_index,
                    input open_count, output ready);
endinterface
`default_nettype wire

FILE: hdl/ghst_table.sv
// Slot table: slot state, first-free search, handle encode/decode and state update.
`default_nettype none
module ghst_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  ghst_pkg::req_t                 req,
    input  logic [ghst_pkg::LIMIT_W-1:0]   open_limit,
    output ghst_pkg::rsp_t                 rsp
);
    import ghst_pkg::*;

    logic                open_reg  [SLOTS];
    logic                open_next [SLOTS];
    logic [GEN_W-1:0]    gen_reg   [SLOTS];
    logic [GEN_W-1:0]    gen_next  [SLOTS];
    logic [KIND_W-1:0]   kind_reg  [SLOTS];
    logic [KIND_W-1:0]   kind_next [SLOTS];
    logic [CNT_W-1:0]    total_reg;
    logic [CNT_W-1:0]    total_next;

    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic                can_reserve;
    logic [GEN_W-1:0]    new_gm1;
    logic [GEN_W-1:0]    new_gen;
    logic [HND_W-1:0]    new_handle;
    logic [HND_W-1:0]    dec_a;
    logic [IDX_W-1:0]    dec_idx;
    logic [GEN_W:0]      dec_gen;
    logic                dec_ok;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!free_found && !open_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign can_reserve = free_found && (total_reg < CNT_W'(open_limit));

    // generation wraps to 1 once a handle would no longer fit
    assign new_gm1    = (gen_reg[free_idx] == GEN_MAX) ? '0 : gen_reg[free_idx];
    assign new_gen    = new_gm1 + GEN_W'(1);
    assign new_handle = {new_gm1, free_idx} + HND_W'(1);

    assign dec_a   = req.handle - HND_W'(1);
    assign dec_idx = dec_a[IDX_W-1:0];
    assign dec_gen = {1'b0, dec_a[HND_W-1:IDX_W]} + (GEN_W+1)'(1);
    assign dec_ok  = (req.handle != '0) && open_reg[dec_idx]
                     && ({1'b0, gen_reg[dec_idx]} == dec_gen)
                     && ((req.mode != MODE_LOOKUP) || (kind_reg[dec_idx] == req.kind));

    always_comb
    begin
        open_next  = open_reg;
        gen_next   = gen_reg;
        kind_next  = kind_reg;
        total_next = total_reg;
        rsp.status     = ST_OK;
        rsp.handle     = '0;
        rsp.slot_index = '0;
        unique case (req.mode)
            MODE_RESERVE:
            begin
                if (can_reserve)
                begin
                    open_next[free_idx] = 1'b1;
                    gen_next[free_idx]  = new_gen;
                    kind_next[free_idx] = req.kind;
                    total_next          = total_reg + CNT_W'(1);
                    rsp.handle          = new_handle;
                    rsp.slot_index      = free_idx;
                end
                else
                begin
                    rsp.status = ST_NO_SLOT;
                end
            end
            MODE_LOOKUP, MODE_CLOSE:
            begin
                if (dec_ok)
                begin
                    rsp.slot_index = dec_idx;
                    if (req.mode == MODE_CLOSE)
                    begin
                        open_next[dec_idx] = 1'b0;
                        kind_next[dec_idx] = '0;
                        if (total_reg != '0)
                        begin
                            total_next = total_reg - CNT_W'(1);
                        end
                    end
                end
                else
                begin
                    rsp.status = ST_BAD_HANDLE;
                end
            end
            MODE_CLOSE_ALL:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    open_next[i] = 1'b0;
                    kind_next[i] = '0;
                end
                total_next = '0;
            end
        endcase
        rsp.open_count = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                open_reg[i] <= 1'b0;
                gen_reg[i]  <= '0;
                kind_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else if (fire)
        begin
            open_reg  <= open_next;
            gen_reg   <= gen_next;
            kind_reg  <= kind_next;
            total_reg <= total_next;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/generational_handle_slot_table_top.sv
// Top level: generational handle slot table with input and result registers.
// Path: a request is held in the input register, passes the slot table and its response is
// held in the result register; response valid rises as the item leaves the input register.
// Throughput: one transaction per cycle while the response is not stalled; the slot table state
// updates as an item leaves the input register, so the next item sees it at once.
// Reset: asynchronous, active low; all slots closed, generations and count zero,
// open_limit back to 8. No clearing pass.
`default_nettype none
module generational_handle_slot_table_top (
    input  logic                           clk,
    input  logic                           rst_n,
    ghst_req_if.sink                       in_ch,
    ghst_rsp_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [ghst_pkg::LIMIT_W-1:0]   cfg_wdata
);
    import ghst_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic               in_valid_reg;
    req_t               in_req_reg;
    logic               out_valid_reg;
    rsp_t               out_rsp_reg;
    rsp_t               rsp;
    logic               advance;

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    ghst_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .req        (in_req_reg),
        .open_limit (limit_reg),
        .rsp        (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            in_valid_reg  <= 1'b0;
            in_req_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                in_req_reg.mode   <= mode_t'(in_ch.mode);
                in_req_reg.kind   <= in_ch.kind;
                in_req_reg.handle <= in_ch.handle_in;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_rsp_reg <= rsp;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = out_rsp_reg.status;
    assign out_ch.handle_out = out_rsp_reg.handle;
    assign out_ch.slot_index = out_rsp_reg.slot_index;
    assign out_ch.open_count = out_rsp_reg.open_count;
endmodule
`default_nettype wire

FILE: hdl/ghst_checker.sv
// Checker: port-level assertions for the handle slot table, bound to the top level.
`default_nettype none
module ghst_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [31:0] handle_out,
    input  logic [2:0]  slot_index,
    input  logic [3:0]  open_count
);
    import ghst_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("response dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(handle_out)
                                    && $stable(slot_index) && $stable(open_count))
        else $error("response changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (handle_out == '0) && (slot_index == '0))
        else $error("failed transaction carries handle or index");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_NO_SLOT)
                      || (status == ST_BAD_HANDLE))
        else $error("bad status code");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (open_count <= CNT_W'(SLOTS))
                      && ((handle_out == '0) || (open_count != '0)))
        else $error("open count out of range");
endmodule

bind generational_handle_slot_table_top ghst_checker u_ghst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .status     (out_ch.status),
    .handle_out (out_ch.handle_out),
    .slot_index (out_ch.slot_index),
    .open_count (out_ch.open_count)
);
`default_nettype wire

FILE: test/testbench.sv
// Testbench for the generational handle slot table: directed and random traffic, self-checking.
`timescale 1ns / 1ps

module testbench;
    import ghst_pkg::*;

    localparam int LATENCY    = 2;
    localparam int IDLE_LIMIT = 1000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;

    ghst_req_if req_ch();
    ghst_rsp_if rsp_ch();

    generational_handle_slot_table_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (req_ch),
        .out_ch    (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the slot table
    logic               tbl_open  [SLOTS];
    logic [HND_W-1:0]   tbl_gen   [SLOTS];
    logic [KIND_W-1:0]  tbl_kind  [SLOTS];
    logic [CNT_W-1:0]   tbl_count;
    logic [LIMIT_W-1:0] tbl_limit;
    logic [HND_W-1:0]   last_handle;

    rsp_t replies_q[$];
    rsp_t want_rsp;

    int mismatch_count;
    int sent_count;
    int checked_count;
    int reserve_ok_count;
    int refused_count;
    int bad_handle_count;
    int close_ok_count;

    int burst_left;
    int no_gaps;
    int hold_off_cycles;
    int rx_style;
    int rx_phase_left;
    int rx_tick;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [HND_W-1:0] make_handle(input logic [HND_W-1:0] g, input int i);
        return (g - 1) * SLOTS + i + 1;
    endfunction

    task automatic table_clear();
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_open[i] = 1'b0;
            tbl_gen[i]  = '0;
            tbl_kind[i] = '0;
        end
        tbl_count = '0;
        tbl_limit = LIMIT_RESET;
    endtask

    task automatic release_slot(input int i);
        if (tbl_open[i])
        begin
            tbl_open[i] = 1'b0;
            tbl_kind[i] = '0;
            if (tbl_count != 0)
                tbl_count = tbl_count - CNT_W'(1);
        end
    endtask

    // Applies one transaction to the shadow table and queues the reply it must produce.
    task automatic table_apply(input req_t r);
        rsp_t             res;
        int               idx;
        logic [HND_W-1:0] g;
        logic [HND_W-1:0] a;
        logic [HND_W-1:0] dgen;
        logic [IDX_W-1:0] di;
        res = '0;
        res.status = ST_OK;
        case (r.mode)
            MODE_RESERVE:
            begin
                idx = -1;
                if (tbl_count < tbl_limit)
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!tbl_open[i])
                            idx = i;
                if (idx < 0)
                begin
                    res.status = ST_NO_SLOT;
                    refused_count++;
                end
                else
                begin
                    g = tbl_gen[idx] + 1;
                    if (g == 0 || g > 32'hFFFF_FFFF / SLOTS)
                        g = 1;
                    tbl_gen[idx]  = g;
                    tbl_open[idx] = 1'b1;
                    tbl_kind[idx] = r.kind;
                    tbl_count     = tbl_count + CNT_W'(1);
                    res.handle     = make_handle(g, idx);
                    res.slot_index = IDX_W'(idx);
                    last_handle    = res.handle;
                    reserve_ok_count++;
                end
            end
            MODE_LOOKUP, MODE_CLOSE:
            begin
                a    = r.handle - 1;
                di   = a[IDX_W-1:0];
                dgen = (a >> IDX_W) + 1;
                if (r.handle == 0 || !tbl_open[di] || tbl_gen[di] != dgen
                    || (r.mode == MODE_LOOKUP && tbl_kind[di] != r.kind))
                begin
                    res.status = ST_BAD_HANDLE;
                    bad_handle_count++;
                end
                else
                begin
                    res.slot_index = di;
                    if (r.mode == MODE_CLOSE)
                    begin
                        release_slot(int'(di));
                        close_ok_count++;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                    release_slot(i);
            end
        endcase
        res.open_count = tbl_count;
        replies_q.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [HND_W-1:0] want,
                                   input logic [HND_W-1:0] got);
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        mismatch_count++;
    endtask

    // Sends one request; returns at the edge where it was accepted.
    task automatic send_item(input mode_t m, input logic [KIND_W-1:0] k,
                             input logic [HND_W-1:0] h);
        req_t r;
        int   gap;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (no_gaps)
            burst_left = 1000;
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= m;
        req_ch.kind      <= k;
        req_ch.handle_in <= h;
        do
            @(posedge clk);
        while (!req_ch.ready);
        burst_left--;
        sent_count++;
        r.mode   = m;
        r.kind   = k;
        r.handle = h;
        table_apply(r);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (replies_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 1) @(posedge clk);
    endtask

    task automatic set_open_limit(input logic [LIMIT_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tbl_limit = v;
    endtask

    function automatic logic [HND_W-1:0] live_handle();
        int cnt;
        int pick;
        cnt = 0;
        for (int i = 0; i < SLOTS; i++)
            if (tbl_open[i])
                cnt++;
        if (cnt == 0)
            return $urandom_range(1, 64);
        pick = $urandom_range(0, cnt - 1);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_open[i])
            begin
                if (pick == 0)
                    return make_handle(tbl_gen[i], i);
                pick--;
            end
        return '0;
    endfunction

    function automatic logic [HND_W-1:0] pick_handle();
        int sel;
        int i;
        sel = $urandom_range(0, 9);
        i   = $urandom_range(0, SLOTS - 1);
        if (sel <= 5)
            return live_handle();
        if (sel == 6)
            return (tbl_gen[i] >= 2) ? make_handle(tbl_gen[i] - 1, i) : make_handle(1, i);
        if (sel == 7)
            return make_handle(tbl_gen[i] + 1, i);
        if (sel == 8)
            return $urandom;
        return $urandom_range(0, 20);
    endfunction

    task automatic random_item();
        int                sel;
        logic [HND_W-1:0]  h;
        logic [HND_W-1:0]  a;
        logic [KIND_W-1:0] k;
        sel = $urandom_range(0, 99);
        h   = pick_handle();
        a   = h - 1;
        k   = KIND_W'($urandom_range(0, 3));
        if (sel < 30)
            send_item(MODE_RESERVE, k, $urandom);
        else if (sel < 55)
        begin
            if (h != 0 && $urandom_range(0, 3) != 0)
                k = tbl_kind[a[IDX_W-1:0]];
            send_item(MODE_LOOKUP, k, h);
        end
        else if (sel < 80)
            send_item(MODE_CLOSE, k, h);
        else if (sel < 83)
            send_item(MODE_CLOSE_ALL, k, h);
        else
            send_item(mode_t'($urandom_range(0, 3)), k, $urandom);
    endtask

    task automatic test_zero_and_empty();
        send_item(MODE_LOOKUP, 2'd0, 32'd0);
        send_item(MODE_CLOSE, 2'd3, 32'd0);
        send_item(MODE_CLOSE_ALL, 2'd0, 32'd0);
        send_item(MODE_LOOKUP, 2'd0, 32'd1);
        send_item(MODE_LOOKUP, 2'd3, 32'hFFFF_FFFF);
        send_item(MODE_CLOSE, 2'd1, 32'hFFFF_FFFF);
    endtask

    task automatic test_fill_and_match();
        logic [HND_W-1:0] h [SLOTS];
        for (int i = 0; i < SLOTS; i++)
        begin
            send_item(MODE_RESERVE, KIND_W'(i % 4), 32'hFFFF_FFFF);
            h[i] = last_handle;
        end
        send_item(MODE_RESERVE, 2'd1, 32'd0);
        send_item(MODE_LOOKUP, 2'd0, h[0]);
        send_item(MODE_LOOKUP, 2'd0, h[1]);
        send_item(MODE_LOOKUP, 2'd3, h[7]);
        send_item(MODE_LOOKUP, 2'd3, h[7] + SLOTS);
        send_item(MODE_CLOSE, 2'd3, h[2]);
        send_item(MODE_CLOSE, 2'd2, h[2]);
        send_item(MODE_LOOKUP, 2'd2, h[2]);
        send_item(MODE_RESERVE, 2'd3, 32'd0);
        send_item(MODE_LOOKUP, 2'd2, h[2]);
        send_item(MODE_LOOKUP, 2'd3, last_handle);
        send_item(MODE_CLOSE_ALL, 2'd0, 32'd0);
        send_item(MODE_LOOKUP, 2'd0, h[0]);
        send_item(MODE_RESERVE, 2'd2, 32'd0);
        send_item(MODE_CLOSE_ALL, 2'd0, 32'd0);
    endtask

    task automatic test_open_limits();
        logic [LIMIT_W-1:0] lims [5];
        lims = '{4'd0, 4'd1, 4'd3, 4'd15, 4'd8};
        foreach (lims[n])
        begin
            wait_drained();
            set_open_limit(lims[n]);
            send_item(MODE_CLOSE_ALL, 2'd0, 32'd0);
            repeat (SLOTS + 1)
                send_item(MODE_RESERVE, KIND_W'($urandom_range(0, 3)), $urandom);
        end
        // Limit dropped below the current count
        send_item(MODE_CLOSE_ALL, 2'd0, 32'd0);
        repeat (5) send_item(MODE_RESERVE, 2'd1, 32'd0);
        wait_drained();
        set_open_limit(4'd2);
        send_item(MODE_RESERVE, 2'd1, 32'd0);
        send_item(MODE_CLOSE, 2'd0, live_handle());
        send_item(MODE_RESERVE, 2'd1, 32'd0);
        send_item(MODE_CLOSE_ALL, 2'd0, 32'd0);
        send_item(MODE_RESERVE, 2'd2, 32'd0);
        wait_drained();
        set_open_limit(4'd8);
    endtask

    task automatic test_backpressure();
        wait_drained();
        no_gaps = 1;
        hold_off_cycles = 80;
        repeat (40) random_item();
        no_gaps = 0;
        burst_left = 0;
    endtask

    task automatic test_random_traffic();
        logic [LIMIT_W-1:0] lims [6];
        lims = '{4'd8, 4'd4, 4'd1, 4'd6, 4'($urandom_range(0, 8)), 4'd8};
        foreach (lims[n])
        begin
            wait_drained();
            set_open_limit(lims[n]);
            repeat (280) random_item();
        end
    endtask

    // Result sink: stall pattern changes from phase to phase
    initial
    begin
        rsp_ch.ready <= 1'b0;
        rx_phase_left = 0;
        rx_tick = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_off_cycles--;
            end
            else
            begin
                if (rx_phase_left == 0)
                begin
                    rx_style = $urandom_range(0, 3);
                    rx_phase_left = $urandom_range(30, 200);
                end
                rx_phase_left--;
                rx_tick++;
                case (rx_style)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                    2: rsp_ch.ready <= (rx_tick % 4 != 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            checked_count++;
            if (replies_q.size() == 0)
                report_mismatch("unexpected transaction", '0, rsp_ch.handle_out);
            else
            begin
                want_rsp = replies_q.pop_front();
                if (rsp_ch.status != want_rsp.status)
                    report_mismatch("status", want_rsp.status, rsp_ch.status);
                if (rsp_ch.handle_out != want_rsp.handle)
                    report_mismatch("handle_out", want_rsp.handle, rsp_ch.handle_out);
                if (rsp_ch.slot_index != want_rsp.slot_index)
                    report_mismatch("slot_index", want_rsp.slot_index, rsp_ch.slot_index);
                if (rsp_ch.open_count != want_rsp.open_count)
                    report_mismatch("open_count", want_rsp.open_count, rsp_ch.open_count);
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.mode      <= MODE_RESERVE;
        req_ch.kind      <= '0;
        req_ch.handle_in <= '0;
        mismatch_count   = 0;
        sent_count       = 0;
        checked_count    = 0;
        reserve_ok_count = 0;
        refused_count    = 0;
        bad_handle_count = 0;
        close_ok_count   = 0;
        burst_left       = 0;
        no_gaps          = 0;
        hold_off_cycles  = 0;
        last_handle      = '0;
        table_clear();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_and_empty();
        test_fill_and_match();
        test_open_limits();
        test_backpressure();
        test_random_traffic();
        wait_drained();

        $display("Sent %0d requests, checked %0d responses, %0d mismatches",
                 sent_count, checked_count, mismatch_count);
        $display("Reserves granted %0d, refused %0d; closes %0d; invalid handles %0d",
                 reserve_ok_count, refused_count, close_ok_count, bad_handle_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
hdl/ghst_pkg.sv
hdl/ghst_if.sv
hdl/ghst_table.sv
hdl/generational_handle_slot_table_top.sv
hdl/ghst_checker.sv
test/testbench.sv
